// ===== rtl/core/sample_capture_ring_snapshot_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the capture buffer
// Shorthand for clocked assertions with reset disable.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_CAPTURE_RING_SNAPSHOT_TOP_ASSERT_SVH
`define SAMPLE_CAPTURE_RING_SNAPSHOT_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("capture buffer assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capture buffer assertion failed");

`endif

// ===== rtl/core/scr_pkg.sv =====
// ---------------------------------------------------------------------------
// scr_pkg
// Shared types and constants for the capture buffer.
// ---------------------------------------------------------------------------
package scr_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_SNAP  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Control handed from the sequencer to the cell chain.
  typedef struct packed {
    logic shift;     // advance every cell by one place
    logic sel_push;  // feed the head from the input sample, else from the tail
  } chain_ctrl_t;

endpackage

// ===== rtl/core/scr_cell.sv =====
// ---------------------------------------------------------------------------
// scr_cell
// One storage cell of the capture chain: holds a word, takes its neighbor's.
// ---------------------------------------------------------------------------
module scr_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [scr_pkg::WORD_W-1:0] d,
  output logic [scr_pkg::WORD_W-1:0] q
);
  import scr_pkg::*;

  logic [WORD_W-1:0] word;

  always_ff @(posedge clk) begin
    if (shift) begin
      word <= d;
    end
  end

  assign q = word;

endmodule

// ===== rtl/core/scr_chain.sv =====
// ---------------------------------------------------------------------------
// scr_chain
// Row of cells, newest at the head, oldest at the tail, tail fed back on rotate.
// ---------------------------------------------------------------------------
module scr_chain #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  scr_pkg::chain_ctrl_t       ctrl,
  input  logic [scr_pkg::WORD_W-1:0] sample,
  output logic [scr_pkg::WORD_W-1:0] tail
);
  import scr_pkg::*;

  logic [WORD_W-1:0] link [DEPTH];
  logic [WORD_W-1:0] head_d;

  // Push brings in a new sample; rotate recirculates the oldest word.
  assign head_d = ctrl.sel_push ? sample : link[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      scr_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d     (head_d),
        .q     (link[i])
      );
    end else begin : g_body
      scr_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d     (link[i-1]),
        .q     (link[i])
      );
    end
  end

  assign tail = link[DEPTH-1];

endmodule

// ===== rtl/core/sample_capture_ring_snapshot_top.sv =====
// ---------------------------------------------------------------------------
// sample_capture_ring_snapshot_top
// Circular capture buffer with full-window snapshot readout.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries action and sample_word:
//   push stores sample_word as the newest sample, clear empties the window,
//   snapshot reads out the whole window; code 3 is dropped with no effect.
// Output channel (out_valid/out_ready) carries window_word and last_word.
// A snapshot yields exactly CAPACITY items: zero words for slots not filled
// since the last clear, then the stored samples oldest first; the final item
// has last_word set.
// Push and clear produce no item, so a stream of pushes is accepted one per
// cycle while no snapshot is being read out. A snapshot rotates the cell chain
// one place per item delivered: acceptance sets busy, then each item loads the
// output register, one item per cycle while the receiver does not stall.
// in_ready is low while a snapshot is being read out; the chain is restored
// to its original order when the last item leaves the chain.
// A receiver stall holds the output register and freezes the rotation.
// Reset empties the window and drops any snapshot in progress; the chain
// contents are not cleared, since unfilled slots always read as zero.
// ---------------------------------------------------------------------------
module sample_capture_ring_snapshot_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 action,
  input  logic [scr_pkg::WORD_W-1:0] sample_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scr_pkg::WORD_W-1:0] window_word,
  output logic                       last_word
);
  import scr_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(CAPACITY - 1);

  logic              busy;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  zeros;
  logic              in_fire;
  logic              push_fire;
  logic              snap_fire;
  logic              clear_fire;
  logic              load;
  logic              last_step;
  action_t           act;
  chain_ctrl_t       ctrl;
  logic [WORD_W-1:0] tail;

  // Accept new items whenever no snapshot is being read out.
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign act      = action_t'(action);

  always_comb begin
    push_fire  = 1'b0;
    snap_fire  = 1'b0;
    clear_fire = 1'b0;
    unique case (act)
      ACT_PUSH:  push_fire  = in_fire;
      ACT_SNAP:  snap_fire  = in_fire;
      ACT_CLEAR: clear_fire = in_fire;
      default: ;
    endcase
  end

  // Advance the readout when the output register is free or being emptied.
  assign load      = busy && (!out_valid || out_ready);
  assign last_step = (step == LAST_C);
  assign zeros     = CAP_C - fill_count;

  assign ctrl.shift    = push_fire || load;
  assign ctrl.sel_push = push_fire;

  scr_chain #(
    .DEPTH (CAPACITY)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (sample_word),
    .tail   (tail)
  );

  // Window fill level: saturate on push, drop to zero on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (clear_fire) begin
      fill_count <= '0;
    end else if (push_fire && (fill_count != CAP_C)) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // Snapshot sequencer: one chain rotation per item handed to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (snap_fire) begin
      busy <= 1'b1;
      step <= '0;
    end else if (load) begin
      step <= step + 1'b1;
      if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Slots older than the current window read as zero.
  always_ff @(posedge clk) begin
    if (load) begin
      window_word <= (step < zeros) ? '0 : tail;
      last_word   <= last_step;
    end
  end

  `include "sample_capture_ring_snapshot_top_assert.svh"

  `SCR_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CAP_C)
  `SCR_ASSERT_NOW(a_step_bound, busy, step < CAP_C)
  `SCR_ASSERT_NEXT(a_snap_starts, snap_fire, busy && (step == '0))
  `SCR_ASSERT_NEXT(a_last_ends, load && last_step, !busy && out_valid && last_word)

endmodule
